>>> hw/rtl/err_pkg.sv
// Shared types, constants and register codes for the expanding ring ramp effect.
package err_pkg;

    localparam int COORD_W = 16;
    localparam int SPEED_W = 24;
    localparam int RADIUS_W = 32;
    localparam int LEVEL_W = 16;
    localparam int ACTION_W = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [ACTION_W-1:0] ACT_START = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_POLL  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_STEPS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE0_STEPS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_FIRST  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_SECOND = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RADIAL_SPEED = 3'd7;

    localparam logic [1:0] PH_ACCEL0 = 2'd0;
    localparam logic [1:0] PH_ACCEL1 = 2'd1;
    localparam logic [1:0] PH_CRUISE = 2'd2;

    // Datapath operations issued by the controller.
    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_START    = 4'd1;
    localparam logic [3:0] OP_TICK_N   = 4'd2;
    localparam logic [3:0] OP_MUL_A    = 4'd3;
    localparam logic [3:0] OP_MUL_B    = 4'd4;
    localparam logic [3:0] OP_MUL_C    = 4'd5;
    localparam logic [3:0] OP_TICK_END = 4'd6;
    localparam logic [3:0] OP_Q_DIFF   = 4'd7;
    localparam logic [3:0] OP_Q_SQ     = 4'd8;
    localparam logic [3:0] OP_Q_SQRT   = 4'd9;
    localparam logic [3:0] OP_Q_CMP    = 4'd10;
    localparam logic [3:0] OP_Q_DIV    = 4'd11;
    localparam logic [3:0] OP_POLL     = 4'd12;
    localparam logic [3:0] OP_Q_MUL2   = 4'd13;

    typedef struct packed {
        logic [3:0] op;
    } err_cmd_t;

    typedef struct packed {
        logic       active;
        logic [1:0] phase;
        logic       iter_done;
        logic       q_early;
    } err_status_t;

endpackage

>>> hw/rtl/err_datapath.sv
// Datapath of the ring effect: configuration, motion state, square root and divider.
module err_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic [err_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [err_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic signed [err_pkg::COORD_W-1:0]   pixel_x,
    input  logic signed [err_pkg::COORD_W-1:0]   pixel_y,
    input  logic                                 load,
    input  err_pkg::err_cmd_t                    cmd,
    output err_pkg::err_status_t                 status,
    output logic [err_pkg::LEVEL_W-1:0]          level_val,
    output logic                                 done_val
);

    localparam int SQ_W = 2 * err_pkg::COORD_W + 2;   // 34-bit squared distance
    localparam int RAD_W = SQ_W + 30;                  // 64-bit radicand
    localparam int ROOT_W = RAD_W / 2;                 // 32-bit root
    localparam int DIV_W = err_pkg::RADIUS_W;
    localparam int LEVEL_W_FIX = err_pkg::LEVEL_W;
    localparam int COORD_W_P1 = err_pkg::COORD_W + 1;

    logic signed [err_pkg::COORD_W-1:0] center_x_reg;
    logic signed [err_pkg::COORD_W-1:0] center_y_reg;
    logic [15:0] ramp_width_reg;
    logic [15:0] total_steps_reg;
    logic [15:0] phase0_steps_reg;
    logic [err_pkg::SPEED_W-1:0] accel_first_reg;
    logic [err_pkg::SPEED_W-1:0] accel_second_reg;
    logic [err_pkg::SPEED_W-1:0] radial_speed_reg;

    logic [err_pkg::RADIUS_W-1:0] radius_reg;
    logic [1:0]  phase_reg;
    logic [15:0] ticks_reg;
    logic [15:0] elapsed_reg;
    logic        active_reg;
    logic        finished_reg;

    logic signed [err_pkg::COORD_W:0] dx_reg, dy_reg;
    logic [SQ_W-1:0]   d2_reg;
    logic [ROOT_W:0]   rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [5:0]        cnt_reg;
    logic [DIV_W-1:0]  e_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [DIV_W:0]    drem_reg;
    logic [17:0]       w2_reg;
    logic [63:0]       acc_reg;
    logic [39:0]       prod_reg;
    logic [LEVEL_W_FIX-1:0] level_reg;
    logic              done_reg;
    logic              early_reg;

    logic [15:0] n_next;
    logic [15:0] t1;
    logic [15:0] w_eff;
    logic [ROOT_W+3:0] trial;
    logic [ROOT_W+2:0] rem_sh;
    logic [ROOT_W:0]  ring_dist;
    logic [DIV_W:0]   drem_sh;
    logic [15:0]      el_next;

    assign n_next = ticks_reg + 16'd1;
    assign t1 = 16'(({1'b0, phase0_steps_reg} + 17'd1) >> 1);
    assign w_eff = (ramp_width_reg < 16'd16) ? 16'd16 : ramp_width_reg;
    assign rem_sh = {rem_reg, acc_reg[RAD_W-1:RAD_W-2]};
    assign trial = {1'b0, rem_sh} - {2'b00, root_reg, 2'b01};
    assign ring_dist = {root_reg, 1'b0};
    assign drem_sh = {drem_reg[DIV_W-1:0], e_reg[DIV_W-1]};
    assign el_next = elapsed_reg + 16'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            ramp_width_reg <= 16'd16;
            total_steps_reg <= 16'd1;
            phase0_steps_reg <= '0;
            accel_first_reg <= '0;
            accel_second_reg <= '0;
            radial_speed_reg <= '0;
            radius_reg <= '0;
            phase_reg <= '0;
            ticks_reg <= '0;
            elapsed_reg <= '0;
            active_reg <= 1'b0;
            finished_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    err_pkg::REG_CENTER_X:     center_x_reg <= cfg_data[15:0];
                    err_pkg::REG_CENTER_Y:     center_y_reg <= cfg_data[15:0];
                    err_pkg::REG_RAMP_WIDTH:   ramp_width_reg <= cfg_data[15:0];
                    err_pkg::REG_TOTAL_STEPS:  total_steps_reg <= cfg_data[15:0];
                    err_pkg::REG_PHASE0_STEPS: phase0_steps_reg <= cfg_data[15:0];
                    err_pkg::REG_ACCEL_FIRST:  accel_first_reg <= cfg_data;
                    err_pkg::REG_ACCEL_SECOND: accel_second_reg <= cfg_data;
                    err_pkg::REG_RADIAL_SPEED: radial_speed_reg <= cfg_data;
                    default: ;
                endcase
            end
            case (cmd.op)
                err_pkg::OP_START:
                begin
                    radius_reg <= '0;
                    ticks_reg <= '0;
                    elapsed_reg <= '0;
                    finished_reg <= 1'b0;
                    phase_reg <= (phase0_steps_reg == 16'd0) ? err_pkg::PH_CRUISE
                                                            : err_pkg::PH_ACCEL0;
                    active_reg <= 1'b1;
                end
                err_pkg::OP_TICK_N: ticks_reg <= n_next;
                err_pkg::OP_TICK_END:
                begin
                    case (phase_reg)
                        err_pkg::PH_ACCEL0, err_pkg::PH_ACCEL1:
                        begin
                            radius_reg <= (acc_reg[63:33] != '0) ? '1 : acc_reg[32:1];
                            if (ticks_reg >= ((phase_reg == err_pkg::PH_ACCEL0)
                                              ? phase0_steps_reg : t1))
                            begin
                                phase_reg <= phase_reg + 2'd1;
                                ticks_reg <= '0;
                            end
                        end
                        err_pkg::PH_CRUISE:
                            radius_reg <= (acc_reg[32]) ? '1 : acc_reg[31:0];
                        default: ;
                    endcase
                    elapsed_reg <= el_next;
                    if (el_next >= total_steps_reg)
                    begin
                        active_reg <= 1'b0;
                        finished_reg <= 1'b1;
                    end
                end
                err_pkg::OP_POLL: finished_reg <= 1'b0;
                default: ;
            endcase
        end
    end

    // Arithmetic working registers; no reset needed.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            level_reg <= '0;
            done_reg <= (cmd.op == err_pkg::OP_POLL) && finished_reg;
        end
        case (cmd.op)
            err_pkg::OP_TICK_N:
            begin
                // prod = a0*n (phase 0) or a0*t0; acc = radius + speed (cruise).
                prod_reg <= 40'(accel_first_reg * ((phase_reg == err_pkg::PH_ACCEL0)
                                                   ? n_next : phase0_steps_reg));
                acc_reg <= 64'(radius_reg) + 64'(radial_speed_reg);
            end
            err_pkg::OP_MUL_A:
            begin
                if (phase_reg == err_pkg::PH_ACCEL0)
                    acc_reg <= 64'(prod_reg * ticks_reg);
                else
                    acc_reg <= 64'(prod_reg * phase0_steps_reg);
            end
            err_pkg::OP_MUL_B:
                if (phase_reg == err_pkg::PH_ACCEL1)
                begin
                    acc_reg <= acc_reg + (64'(prod_reg * ticks_reg) << 1);
                    prod_reg <= 40'(accel_second_reg * ticks_reg);
                end
            err_pkg::OP_MUL_C:
                if (phase_reg == err_pkg::PH_ACCEL1)
                    acc_reg <= acc_reg + 64'(prod_reg * ticks_reg);
            err_pkg::OP_Q_DIFF:
            begin
                dx_reg <= (COORD_W_P1)'(pixel_x) - (COORD_W_P1)'(center_x_reg);
                dy_reg <= (COORD_W_P1)'(pixel_y) - (COORD_W_P1)'(center_y_reg);
                early_reg <= !active_reg;
            end
            err_pkg::OP_Q_SQ:
                d2_reg <= SQ_W'(unsigned'(34'(dx_reg * dx_reg)));
            err_pkg::OP_Q_MUL2:
            begin
                acc_reg <= {d2_reg + SQ_W'(unsigned'(34'(dy_reg * dy_reg))), 30'd0};
                root_reg <= '0;
                cnt_reg <= '0;
                rem_reg <= '0;
            end
            err_pkg::OP_Q_SQRT:
            begin
                // Digit-by-digit root: two radicand bits a cycle.
                acc_reg <= {acc_reg[RAD_W-3:0], 2'b00};
                if (trial[ROOT_W+3])
                begin
                    rem_reg <= rem_sh[ROOT_W:0];
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
                else
                begin
                    rem_reg <= trial[ROOT_W:0];
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end
                cnt_reg <= cnt_reg + 6'd1;
            end
            err_pkg::OP_Q_CMP:
            begin
                e_reg <= radius_reg - ring_dist[DIV_W-1:0];
                w2_reg <= {1'b0, w_eff, 1'b0};
                drem_reg <= '0;
                quo_reg <= '0;
                cnt_reg <= '0;
                if (early_reg || ring_dist >= {1'b0, radius_reg})
                    early_reg <= 1'b1;
                else if ((radius_reg - ring_dist[DIV_W-1:0]) > {w_eff, 16'd0})
                begin
                    early_reg <= 1'b1;
                    level_reg <= 16'h8000;
                end
            end
            err_pkg::OP_Q_DIV:
            begin
                e_reg <= {e_reg[DIV_W-2:0], 1'b0};
                cnt_reg <= cnt_reg + 6'd1;
                if (drem_sh >= (DIV_W+1)'(w2_reg))
                begin
                    drem_reg <= drem_sh - (DIV_W+1)'(w2_reg);
                    quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
                end
                else
                begin
                    drem_reg <= drem_sh;
                    quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
                end
                if (cnt_reg == 6'(DIV_W - 1))
                    level_reg <= (drem_sh >= (DIV_W+1)'(w2_reg))
                                 ? {quo_reg[LEVEL_W_FIX-2:0], 1'b1}
                                 : {quo_reg[LEVEL_W_FIX-2:0], 1'b0};
            end
            default: ;
        endcase
    end

    // The root and the quotient both take 32 steps.
    assign status.active = active_reg;
    assign status.phase = phase_reg;
    assign status.iter_done = (cnt_reg == 6'(ROOT_W - 1));
    assign status.q_early = early_reg;
    assign level_val = level_reg;
    assign done_val = done_reg;

endmodule

>>> hw/rtl/err_ctrl.sv
// Controller state machine sequencing each word through the datapath.
module err_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [err_pkg::ACTION_W-1:0]  action,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          load,
    output err_pkg::err_cmd_t             cmd,
    input  err_pkg::err_status_t          status
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MA    = 4'd2;
    localparam logic [3:0] S_MB    = 4'd3;
    localparam logic [3:0] S_MC    = 4'd4;
    localparam logic [3:0] S_TE    = 4'd5;
    localparam logic [3:0] S_QSQ   = 4'd6;
    localparam logic [3:0] S_QM2   = 4'd7;
    localparam logic [3:0] S_QRT   = 4'd8;
    localparam logic [3:0] S_QCMP  = 4'd9;
    localparam logic [3:0] S_QDIV  = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign load = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg;
        cmd.op = err_pkg::OP_NONE;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
                if (load)
                begin
                    case (action)
                        err_pkg::ACT_START:
                        begin
                            cmd.op = err_pkg::OP_START;
                            state_next = S_OUT;
                        end
                        err_pkg::ACT_TICK:
                            if (status.active)
                            begin
                                cmd.op = err_pkg::OP_TICK_N;
                                state_next = S_MA;
                            end
                            else
                                state_next = S_OUT;
                        err_pkg::ACT_QUERY:
                        begin
                            cmd.op = err_pkg::OP_Q_DIFF;
                            state_next = S_QSQ;
                        end
                        default:
                        begin
                            cmd.op = err_pkg::OP_POLL;
                            state_next = S_OUT;
                        end
                    endcase
                end
            S_MA:
            begin
                cmd.op = (status.phase == err_pkg::PH_CRUISE) ? err_pkg::OP_NONE
                                                             : err_pkg::OP_MUL_A;
                state_next = S_MB;
            end
            S_MB:
            begin
                cmd.op = err_pkg::OP_MUL_B;
                state_next = S_MC;
            end
            S_MC:
            begin
                cmd.op = err_pkg::OP_MUL_C;
                state_next = S_TE;
            end
            S_TE:
            begin
                cmd.op = err_pkg::OP_TICK_END;
                state_next = S_OUT;
            end
            S_QSQ:
            begin
                cmd.op = err_pkg::OP_Q_SQ;
                state_next = S_QM2;
            end
            S_QM2:
            begin
                cmd.op = err_pkg::OP_Q_MUL2;
                state_next = S_QRT;
            end
            S_QRT:
            begin
                cmd.op = err_pkg::OP_Q_SQRT;
                if (status.iter_done)
                    state_next = S_QCMP;
            end
            S_QCMP:
            begin
                cmd.op = err_pkg::OP_Q_CMP;
                state_next = S_QDIV;
            end
            S_QDIV:
                if (status.q_early)
                    state_next = S_OUT;
                else
                begin
                    cmd.op = err_pkg::OP_Q_DIV;
                    if (status.iter_done)
                        state_next = S_OUT;
                end
            S_OUT:
            begin
                out_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hw/rtl/expanding_ring_ramp_effect_top.sv
// Top level of the expanding ring ramp effect generator.
// One word is handled at a time. A tick while the effect is idle leaves the motion state
// alone, and a pixel query runs the 32-step square root that takes two radicand bits a
// cycle and then the 32-step divider that runs one bit a cycle; a query whose pixel lies
// outside the ring or past the ramp, or that arrives while the effect is idle, skips the
// divider. A result word is held until taken, and the next word is accepted once it has
// gone.
module expanding_ring_ramp_effect_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [err_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [err_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [err_pkg::ACTION_W-1:0]        action,
    input  logic signed [err_pkg::COORD_W-1:0]  pixel_x,
    input  logic signed [err_pkg::COORD_W-1:0]  pixel_y,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [err_pkg::LEVEL_W-1:0]         level,
    output logic                                running,
    output logic                                done_res
);

    err_pkg::err_cmd_t    cmd;
    err_pkg::err_status_t status;
    logic                 load;

    assign cfg_ready = 1'b1;
    assign running = status.active;

    err_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .out_valid(out_valid), .out_ready(out_ready),
        .load(load), .cmd(cmd), .status(status)
    );

    err_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .pixel_x(pixel_x), .pixel_y(pixel_y), .load(load),
        .cmd(cmd), .status(status), .level_val(level), .done_val(done_res)
    );

    a_io_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("input taken while result pending");
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (level <= 16'h8000)) else $error("level above full scale");
    a_done_only_poll: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> (level == '0)) else $error("done with level");

endmodule

>>> bench/expanding_ring_ramp_effect_top_tb.sv
// Self-checking testbench for the expanding ring ramp effect generator.
`timescale 1ns / 100ps

module expanding_ring_ramp_effect_top_tb;

    typedef struct packed {
        logic [err_pkg::ACTION_W-1:0] act;
        logic signed [15:0]  px;
        logic signed [15:0]  py;
    } word_t;

    typedef struct packed {
        logic [15:0] lvl;
        logic        run;
        logic        done;
    } result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [err_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [err_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [err_pkg::ACTION_W-1:0] action = '0;
    logic signed [15:0] pixel_x = '0;
    logic signed [15:0] pixel_y = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [15:0] level;
    logic running;
    logic done_res;

    expanding_ring_ramp_effect_top DUT (.*);

    always #1 clk = ~clk;

    // Predictor state and registers.
    logic signed [15:0] cx, cy;
    logic [15:0] rw, tsteps, t0r;
    logic [23:0] a0r, a1r, spd;
    logic [31:0] radius;
    logic [1:0] mphase;
    logic [15:0] pticks, eticks;
    logic eff_on, fin;

    word_t pending_words[$];
    result_t expected_results[$];
    int sender_idle = 0, receiver_idle = 0;
    int hold_off = 0;
    int accepted = 0, received = 0, mismatches = 0, quiet = 0;
    int queries_lit = 0;
    bit timed_out = 0;
    bit in_taken = 0;

    function automatic logic [31:0] sat(logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic logic [63:0] root64(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic void reset_model();
        cx = 0; cy = 0; rw = 16; tsteps = 1; t0r = 0;
        a0r = 0; a1r = 0; spd = 0;
        radius = 0; mphase = err_pkg::PH_ACCEL0; pticks = 0; eticks = 0;
        eff_on = 0; fin = 0;
    endfunction

    function automatic result_t ring_response(word_t w);
        result_t r;
        logic [63:0] n, t0, a0, a1, t1, d2, dst, e, wd;
        logic signed [63:0] dx, dy;
        r = '0;
        case (w.act)
            err_pkg::ACT_START:
            begin
                radius = 0; pticks = 0; eticks = 0; fin = 0;
                mphase = (t0r == 0) ? err_pkg::PH_CRUISE : err_pkg::PH_ACCEL0;
                eff_on = 1;
            end
            err_pkg::ACT_TICK:
            begin
                if (eff_on)
                begin
                    pticks = pticks + 16'd1;
                    n = 64'(pticks); t0 = 64'(t0r); a0 = 64'(a0r); a1 = 64'(a1r);
                    if (mphase == err_pkg::PH_ACCEL0)
                    begin
                        radius = sat((a0 * n * n) >> 1);
                        if (n >= t0)
                        begin
                            mphase = err_pkg::PH_ACCEL1; pticks = 0;
                        end
                    end else if (mphase == err_pkg::PH_ACCEL1)
                    begin
                        t1 = (t0 + 1) >> 1;
                        radius = sat((a0 * t0 * t0 + 2 * a0 * t0 * n + a1 * n * n) >> 1);
                        if (n >= t1)
                        begin
                            mphase = err_pkg::PH_CRUISE; pticks = 0;
                        end
                    end else if (mphase == err_pkg::PH_CRUISE)
                    begin
                        radius = sat({32'd0, radius} + 64'(spd));
                    end
                    eticks = eticks + 16'd1;
                    if (eticks >= tsteps)
                    begin
                        eff_on = 0; fin = 1;
                    end
                end
            end
            err_pkg::ACT_QUERY:
            begin
                if (eff_on)
                begin
                    dx = 64'(w.px) - 64'(cx);
                    dy = 64'(w.py) - 64'(cy);
                    d2 = dx * dx + dy * dy;
                    dst = 2 * root64(d2 << 30);
                    if (dst < 64'(radius))
                    begin
                        e = 64'(radius) - dst;
                        wd = (rw < 16) ? 64'd16 : 64'(rw);
                        if (e > (wd << 16)) r.lvl = 16'd32768;
                        else r.lvl = 16'(e / (2 * wd));
                        queries_lit++;
                    end
                end
            end
            default:
            begin
                r.done = fin; fin = 0;
            end
        endcase
        r.run = eff_on;
        return r;
    endfunction

    // Driver.
    always @(negedge clk)
    begin
        if (!in_valid || in_taken)
        begin
            if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle)
            begin
                word_t w;
                w = pending_words.pop_front();
                expected_results.push_back(ring_response(w));
                action <= w.act; pixel_x <= w.px; pixel_y <= w.py;
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver.
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= receiver_idle);
        end
    end

    // Monitor and watchdog.
    always @(posedge clk)
    begin
        in_taken <= in_valid && in_ready;
        if (in_valid && in_ready) accepted++;
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet > 20000) timed_out = 1;
        end
        if (out_valid && out_ready)
        begin
            result_t e;
            received++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word");
            end else begin
                e = expected_results.pop_front();
                if (e.lvl !== level || e.run !== running || e.done !== done_res)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp level %0d run %0d done %0d, got %0d %0d %0d",
                                 e.lvl, e.run, e.done, level, running, done_res);
                end
            end
        end
    end

    task automatic write_reg(logic [err_pkg::CFG_IDX_W-1:0] idx, logic [23:0] val);
        @(negedge clk);
        cfg_index <= idx; cfg_data <= val; cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            err_pkg::REG_CENTER_X: cx = val[15:0];
            err_pkg::REG_CENTER_Y: cy = val[15:0];
            err_pkg::REG_RAMP_WIDTH: rw = val[15:0];
            err_pkg::REG_TOTAL_STEPS: tsteps = val[15:0];
            err_pkg::REG_PHASE0_STEPS: t0r = val[15:0];
            err_pkg::REG_ACCEL_FIRST: a0r = val;
            err_pkg::REG_ACCEL_SECOND: a1r = val;
            default: spd = val;
        endcase
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || expected_results.size() != 0 || in_valid)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    function automatic void add(logic [1:0] a, logic [15:0] x, logic [15:0] y);
        word_t w;
        w.act = a; w.px = x; w.py = y;
        pending_words.push_back(w);
    endfunction

    // An effect with random content: start, ticks interleaved with queries, polls.
    function automatic void add_effect(int len);
        add(err_pkg::ACT_START, 16'($urandom), 16'($urandom));
        for (int i = 0; i < len; i++)
        begin
            int k;
            k = $urandom_range(9);
            if (k < 4) add(err_pkg::ACT_TICK, 16'($urandom), 16'($urandom));
            else if (k < 8)
                add(err_pkg::ACT_QUERY,
                    cx + $signed(16'($urandom_range(0, 2047)) - 16'sd1024),
                    cy + $signed(16'($urandom_range(0, 2047)) - 16'sd1024));
            else if (k < 9) add(err_pkg::ACT_QUERY, 16'($urandom), 16'($urandom));
            else add(err_pkg::ACT_POLL, 16'($urandom), 16'($urandom));
        end
        add(err_pkg::ACT_POLL, 0, 0);
    endfunction

    initial
    begin
        reset_model();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset settings, then extremes of fields and registers.
        add(err_pkg::ACT_POLL, 0, 0);
        add(err_pkg::ACT_QUERY, 16'h8000, 16'h7FFF);
        add(err_pkg::ACT_TICK, 0, 0);
        add(err_pkg::ACT_START, 0, 0);
        add(err_pkg::ACT_QUERY, 0, 0);
        add(err_pkg::ACT_TICK, 0, 0);
        add(err_pkg::ACT_TICK, 0, 0);
        add(err_pkg::ACT_POLL, 0, 0);
        add(err_pkg::ACT_POLL, 0, 0);
        drain();
        write_reg(err_pkg::REG_CENTER_X, 24'h008000);
        write_reg(err_pkg::REG_CENTER_Y, 24'h007FFF);
        write_reg(err_pkg::REG_RAMP_WIDTH, 24'd0);
        write_reg(err_pkg::REG_TOTAL_STEPS, 24'd0);
        write_reg(err_pkg::REG_PHASE0_STEPS, 24'd0);
        write_reg(err_pkg::REG_ACCEL_FIRST, 24'hFFFFFF);
        write_reg(err_pkg::REG_ACCEL_SECOND, 24'hFFFFFF);
        write_reg(err_pkg::REG_RADIAL_SPEED, 24'hFFFFFF);
        add(err_pkg::ACT_START, 0, 0);
        add(err_pkg::ACT_TICK, 0, 0);
        add(err_pkg::ACT_POLL, 0, 0);
        drain();
        write_reg(err_pkg::REG_TOTAL_STEPS, 24'hFFFF);
        add(err_pkg::ACT_START, 0, 0);
        for (int i = 0; i < 5; i++) add(err_pkg::ACT_TICK, 0, 0);
        add(err_pkg::ACT_QUERY, 16'h7FFF, 16'h8000);
        add(err_pkg::ACT_QUERY, 16'h8000, 16'h7FFF);
        add(err_pkg::ACT_QUERY, 16'h0000, 16'hFFFF);
        drain();
        write_reg(err_pkg::REG_PHASE0_STEPS, 24'hFFFF);
        add(err_pkg::ACT_START, 0, 0);
        for (int i = 0; i < 3; i++) add(err_pkg::ACT_TICK, 0, 0);
        add(err_pkg::ACT_QUERY, 16'h8000, 16'h7FFF);
        drain();

        // Random phases with differing idling and settings.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin sender_idle = 0; receiver_idle = 0; end
                1: begin sender_idle = 72; receiver_idle = 0; end
                2: begin sender_idle = 0; receiver_idle = 72; end
                default: begin sender_idle = 21; receiver_idle = 21; end
            endcase
            write_reg(err_pkg::REG_CENTER_X, 24'($urandom));
            write_reg(err_pkg::REG_CENTER_Y, 24'($urandom));
            write_reg(err_pkg::REG_RAMP_WIDTH,
                      (ph == 7) ? 24'hFFFF : 24'($urandom_range(1, 600)));
            write_reg(err_pkg::REG_TOTAL_STEPS,
                      (ph == 6) ? 24'd1 : 24'($urandom_range(5, 60)));
            write_reg(err_pkg::REG_PHASE0_STEPS,
                      (ph % 2) ? 24'd0 : 24'($urandom_range(1, 12)));
            write_reg(err_pkg::REG_ACCEL_FIRST, 24'($urandom_range(0, 24'h1FFFFF)));
            write_reg(err_pkg::REG_ACCEL_SECOND, 24'($urandom_range(0, 24'h1FFFFF)));
            write_reg(err_pkg::REG_RADIAL_SPEED,
                      (ph == 5) ? 24'd0 : 24'($urandom_range(0, 24'h3FFFFF)));
            if (ph == 2) hold_off = 400;
            for (int j = 0; j < 6; j++) add_effect($urandom_range(15, 40));
            drain();
        end

        if (timed_out || mismatches != 0)
            $display("expanding_ring_ramp_effect_top_tb: FAIL");
        else
        begin
            $display("Covered %0d words in, %0d results out, %0d lit pixel queries.",
                     accepted, received, queries_lit);
            $display("expanding_ring_ramp_effect_top_tb: PASS");
        end
        $finish;
    end

    initial
    begin
        wait (timed_out);
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("expanding_ring_ramp_effect_top_tb: FAIL");
        $finish;
    end
endmodule
